FILE: rtl/hck_pkg.sv
// hck_pkg: shared types and constants for the HSV chroma-key compositor.
// No dependencies; used by hsv_chroma_key_compositor_top.
package hck_pkg;

    localparam int unsigned CH_W    = 8;     // colour channel width
    localparam int unsigned HUE_W   = 9;     // hue bound width, whole degrees
    localparam int unsigned THR_W   = 7;     // sat/val threshold width, hundredths
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 9;

    localparam int unsigned PROD_W  = 15;    // 100*d, t*max, 255*t, blend sums
    localparam int unsigned HNUM_W  = 17;    // hue numerator and band limits

    // reset values of the configuration registers
    localparam logic [HUE_W-1:0] HUE_LOW_RST  = 9'd60;
    localparam logic [HUE_W-1:0] HUE_HIGH_RST = 9'd130;
    localparam logic [THR_W-1:0] KEY_SAT_RST  = 7'd40;
    localparam logic [THR_W-1:0] KEY_VAL_RST  = 7'd30;
    localparam logic [THR_W-1:0] EDGE_SAT_RST = 7'd20;
    localparam logic [THR_W-1:0] EDGE_VAL_RST = 7'd20;

    // blend weights in hundredths
    localparam logic [6:0] W_RB_FG_A = 7'd42;
    localparam logic [6:0] W_RB_BG_A = 7'd70;
    localparam logic [6:0] W_G_FG_A  = 7'd30;
    localparam logic [6:0] W_G_BG_A  = 7'd70;
    localparam logic [6:0] W_RB_FG_B = 7'd60;
    localparam logic [6:0] W_RB_BG_B = 7'd50;
    localparam logic [6:0] W_G_FG_B  = 7'd50;
    localparam logic [6:0] W_G_BG_B  = 7'd50;

    // floor(x/100) = (x*5243) >> 19, exact for x below 43699
    localparam logic [12:0]  DIV100_RECIP = 13'd5243;
    localparam int unsigned  DIV100_SHIFT = 19;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HUE_LOW  = 3'd0,
        CFG_HUE_HIGH = 3'd1,
        CFG_KEY_SAT  = 3'd2,
        CFG_KEY_VAL  = 3'd3,
        CFG_EDGE_SAT = 3'd4,
        CFG_EDGE_VAL = 3'd5
    } t_cfg_idx;

    // which channel is largest, and whether the red hue wraps round
    typedef enum logic [1:0] {
        HS_RED      = 2'd0,
        HS_RED_WRAP = 2'd1,
        HS_GREEN    = 2'd2,
        HS_BLUE     = 2'd3
    } t_hsel;

    typedef enum logic [1:0] {
        KIND_PASS = 2'd0,
        KIND_EDGE = 2'd1,
        KIND_KEY  = 2'd2
    } t_kind;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_pix;

endpackage

FILE: rtl/hsv_chroma_key_compositor_top.sv
// hsv_chroma_key_compositor_top: four-stage pipelined HSV chroma keyer and blender.
// Depends on hck_pkg (types, weights, reciprocal constant).
//
//  channel   | direction | fields (tdata, lowest bits first)
//  s_axis    | in        | fg_red, fg_green, fg_blue, bg_red, bg_green, bg_blue
//  m_axis    | out       | out_red, out_green, out_blue, alpha
//  cfg       | in        | index 0..5 selects a register, data in the low bits
//
// One item per clock unless the output stalls; each item is registered in every stage.
// Stages: min/max/hue select, products, compares and blend select,
// divide by 100 and output mux. Each stage holds its own valid bit and
// moves on when the stage after it is empty or moving, so a stall at the
// output fills the bubbles before o_s_axis_tready drops.
// Synchronous active-low reset empties the pipeline and reloads the registers.
module hsv_chroma_key_compositor_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // fg_red, fg_green, fg_blue, bg_red, bg_green, bg_blue
    input  logic [47:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // out_red, out_green, out_blue, alpha
    output logic [31:0] o_m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [hck_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [hck_pkg::CFG_DAT_W-1:0] i_cfg_data
);

    localparam int unsigned CW = hck_pkg::CH_W;
    localparam int unsigned PW = hck_pkg::PROD_W;
    localparam int unsigned NW = hck_pkg::HNUM_W;

    // ---------------- configuration ----------------
    logic [hck_pkg::HUE_W-1:0] r_hue_low, r_hue_high;
    logic [hck_pkg::THR_W-1:0] r_key_sat, r_key_val, r_edge_sat, r_edge_val;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hue_low  <= hck_pkg::HUE_LOW_RST;
            r_hue_high <= hck_pkg::HUE_HIGH_RST;
            r_key_sat  <= hck_pkg::KEY_SAT_RST;
            r_key_val  <= hck_pkg::KEY_VAL_RST;
            r_edge_sat <= hck_pkg::EDGE_SAT_RST;
            r_edge_val <= hck_pkg::EDGE_VAL_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                hck_pkg::CFG_HUE_LOW:  r_hue_low  <= i_cfg_data;
                hck_pkg::CFG_HUE_HIGH: r_hue_high <= i_cfg_data;
                hck_pkg::CFG_KEY_SAT:  r_key_sat  <= i_cfg_data[hck_pkg::THR_W-1:0];
                hck_pkg::CFG_KEY_VAL:  r_key_val  <= i_cfg_data[hck_pkg::THR_W-1:0];
                hck_pkg::CFG_EDGE_SAT: r_edge_sat <= i_cfg_data[hck_pkg::THR_W-1:0];
                hck_pkg::CFG_EDGE_VAL: r_edge_val <= i_cfg_data[hck_pkg::THR_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- flow control ----------------
    logic r_v1, r_v2, r_v3, r_v4;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4;

    assign w_rdy4 = !r_v4 || i_m_axis_tready;
    assign w_rdy3 = !r_v3 || w_rdy4;
    assign w_rdy2 = !r_v2 || w_rdy3;
    assign w_rdy1 = !r_v1 || w_rdy2;
    assign o_s_axis_tready = w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_s_axis_tvalid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
            if (w_rdy4) r_v4 <= r_v3;
        end
    end

    // ---------------- stage 1: max, min, hue select ----------------
    hck_pkg::t_pix w_fg, w_bg;
    assign w_fg = '{red: i_s_axis_tdata[7:0], green: i_s_axis_tdata[15:8],
                    blue: i_s_axis_tdata[23:16]};
    assign w_bg = '{red: i_s_axis_tdata[31:24], green: i_s_axis_tdata[39:32],
                    blue: i_s_axis_tdata[47:40]};

    logic [CW-1:0]   n_mx, n_mn;
    logic [CW:0]     n_diff;
    hck_pkg::t_hsel  n_hsel;

    always_comb begin
        if (w_fg.red >= w_fg.green && w_fg.red >= w_fg.blue) begin
            n_mx   = w_fg.red;
            n_diff = {1'b0, w_fg.green} - {1'b0, w_fg.blue};
            n_hsel = (w_fg.green < w_fg.blue) ? hck_pkg::HS_RED_WRAP : hck_pkg::HS_RED;
        end else if (w_fg.green >= w_fg.blue) begin
            n_mx   = w_fg.green;
            n_diff = {1'b0, w_fg.blue} - {1'b0, w_fg.red};
            n_hsel = hck_pkg::HS_GREEN;
        end else begin
            n_mx   = w_fg.blue;
            n_diff = {1'b0, w_fg.red} - {1'b0, w_fg.green};
            n_hsel = hck_pkg::HS_BLUE;
        end
        n_mn = w_fg.red;
        if (w_fg.green < n_mn) n_mn = w_fg.green;
        if (w_fg.blue < n_mn)  n_mn = w_fg.blue;
    end

    logic [CW-1:0]   r1_mx, r1_d;
    logic [CW:0]     r1_diff;
    hck_pkg::t_hsel  r1_hsel;
    hck_pkg::t_pix   r1_fg, r1_bg;

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r1_mx   <= n_mx;
            r1_d    <= n_mx - n_mn;
            r1_diff <= n_diff;
            r1_hsel <= n_hsel;
            r1_fg   <= w_fg;
            r1_bg   <= w_bg;
        end
    end

    // ---------------- stage 2: products ----------------
    logic [NW-1:0] n_base, n_num;
    logic [PW-1:0] n_diff60;

    always_comb begin
        unique case (r1_hsel)
            hck_pkg::HS_RED:      n_base = '0;
            hck_pkg::HS_RED_WRAP: n_base = NW'(r1_d) * NW'(360);
            hck_pkg::HS_GREEN:    n_base = NW'(r1_d) * NW'(120);
            hck_pkg::HS_BLUE:     n_base = NW'(r1_d) * NW'(240);
            default:              n_base = '0;
        endcase
        // signed diff, modular arithmetic: the true sum is never negative
        n_diff60 = {{(PW-CW-1){r1_diff[CW]}}, r1_diff} * PW'(60);
        n_num    = n_base + {{(NW-PW){n_diff60[PW-1]}}, n_diff60};
    end

    logic [NW-1:0] r2_num, r2_lo, r2_hi;
    logic [PW-1:0] r2_sat100, r2_ksat_p, r2_esat_p, r2_val100, r2_kval_p, r2_eval_p;
    logic          r2_mx_zero, r2_d_zero;
    logic [2*CW-1:0] r2_gg, r2_rb;
    logic [PW-1:0] r2_red_a, r2_red_b, r2_grn_a, r2_grn_b, r2_blu_a, r2_blu_b;
    hck_pkg::t_pix r2_fg, r2_bg;

    always_ff @(posedge i_clk) begin
        if (w_rdy2) begin
            r2_num     <= n_num;
            r2_lo      <= NW'(r_hue_low)  * NW'(r1_d);
            r2_hi      <= NW'(r_hue_high) * NW'(r1_d);
            r2_sat100  <= PW'(r1_d) * PW'(100);
            r2_ksat_p  <= PW'(r_key_sat)  * PW'(r1_mx);
            r2_esat_p  <= PW'(r_edge_sat) * PW'(r1_mx);
            r2_val100  <= PW'(r1_mx) * PW'(100);
            r2_kval_p  <= PW'(r_key_val)  * PW'(255);
            r2_eval_p  <= PW'(r_edge_val) * PW'(255);
            r2_mx_zero <= (r1_mx == '0);
            r2_d_zero  <= (r1_d == '0);
            r2_gg      <= (2*CW)'(r1_fg.green) * (2*CW)'(r1_fg.green);
            r2_rb      <= (2*CW)'(r1_fg.red) * (2*CW)'(r1_fg.blue);
            r2_red_a   <= PW'(r1_fg.red) * PW'(hck_pkg::W_RB_FG_A)
                        + PW'(r1_bg.red) * PW'(hck_pkg::W_RB_BG_A);
            r2_red_b   <= PW'(r1_fg.red) * PW'(hck_pkg::W_RB_FG_B)
                        + PW'(r1_bg.red) * PW'(hck_pkg::W_RB_BG_B);
            r2_grn_a   <= PW'(r1_fg.green) * PW'(hck_pkg::W_G_FG_A)
                        + PW'(r1_bg.green) * PW'(hck_pkg::W_G_BG_A);
            r2_grn_b   <= PW'(r1_fg.green) * PW'(hck_pkg::W_G_FG_B)
                        + PW'(r1_bg.green) * PW'(hck_pkg::W_G_BG_B);
            r2_blu_a   <= PW'(r1_fg.blue) * PW'(hck_pkg::W_RB_FG_A)
                        + PW'(r1_bg.blue) * PW'(hck_pkg::W_RB_BG_A);
            r2_blu_b   <= PW'(r1_fg.blue) * PW'(hck_pkg::W_RB_FG_B)
                        + PW'(r1_bg.blue) * PW'(hck_pkg::W_RB_BG_B);
            r2_fg      <= r1_fg;
            r2_bg      <= r1_bg;
        end
    end

    // ---------------- stage 3: compares, classify ----------------
    logic n_in_band, n_key_sat, n_edge_sat, n_key, n_edge, n_sel_a;
    hck_pkg::t_kind n_kind;

    always_comb begin
        // grey pixel: hue is 0
        n_in_band  = r2_d_zero ? (r_hue_low == '0)
                               : (r2_num >= r2_lo && r2_num <= r2_hi);
        // black pixel: saturation 0
        n_key_sat  = r2_mx_zero ? (r_key_sat == '0)  : (r2_sat100 >= r2_ksat_p);
        n_edge_sat = r2_mx_zero ? (r_edge_sat == '0) : (r2_sat100 >= r2_esat_p);
        n_key      = n_in_band && n_key_sat  && (r2_val100 >= r2_kval_p);
        n_edge     = n_in_band && n_edge_sat && (r2_val100 >= r2_eval_p);
        n_sel_a    = (r2_rb != '0) && ({1'b0, r2_gg} >= {r2_rb, 1'b0});
        if (n_key)       n_kind = hck_pkg::KIND_KEY;
        else if (n_edge) n_kind = hck_pkg::KIND_EDGE;
        else             n_kind = hck_pkg::KIND_PASS;
    end

    hck_pkg::t_kind r3_kind;
    logic [PW-1:0]  r3_sum_r, r3_sum_g, r3_sum_b;
    hck_pkg::t_pix  r3_fg, r3_bg;

    always_ff @(posedge i_clk) begin
        if (w_rdy3) begin
            r3_kind  <= n_kind;
            r3_sum_r <= n_sel_a ? r2_red_a : r2_red_b;
            r3_sum_g <= n_sel_a ? r2_grn_a : r2_grn_b;
            r3_sum_b <= n_sel_a ? r2_blu_a : r2_blu_b;
            r3_fg    <= r2_fg;
            r3_bg    <= r2_bg;
        end
    end

    // ---------------- stage 4: divide by 100, saturate, output mux ----------------
    function automatic logic [CW-1:0] div100_sat(input logic [PW-1:0] x);
        logic [PW+12:0] prod;
        logic [CW:0]    q;
        prod = (PW+13)'(x) * (PW+13)'(hck_pkg::DIV100_RECIP);
        q    = prod[hck_pkg::DIV100_SHIFT +: (CW+1)];
        return q[CW] ? {CW{1'b1}} : q[CW-1:0];
    endfunction

    hck_pkg::t_pix n_pix;
    logic [CW-1:0] n_alpha;

    always_comb begin
        unique case (r3_kind)
            hck_pkg::KIND_KEY: begin
                n_pix   = r3_bg;
                n_alpha = '0;
            end
            hck_pkg::KIND_EDGE: begin
                n_pix   = '{red: div100_sat(r3_sum_r), green: div100_sat(r3_sum_g),
                            blue: div100_sat(r3_sum_b)};
                n_alpha = '1;
            end
            default: begin
                n_pix   = r3_fg;
                n_alpha = '1;
            end
        endcase
    end

    hck_pkg::t_pix r4_pix;
    logic [CW-1:0] r4_alpha;

    always_ff @(posedge i_clk) begin
        if (w_rdy4) begin
            r4_pix   <= n_pix;
            r4_alpha <= n_alpha;
        end
    end

    assign o_m_axis_tvalid = r_v4;
    assign o_m_axis_tdata  = {r4_alpha, r4_pix.blue, r4_pix.green, r4_pix.red};

    // ---------------- assertions ----------------
    a_alpha_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[31:24] == 8'd0 || o_m_axis_tdata[31:24] == 8'd255))
        else $error("alpha neither 0 nor 255");

    a_full_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (r_v1 && r_v2 && r_v3 && r_v4 && !i_m_axis_tready))
        else $error("input stalled with room in the pipeline");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(r_v3))
        else $error("output item without a stage-3 item behind it");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid straight after reset");

endmodule
